@@ src/latency_stats_percentile_core_macros.svh @@
// Assertion macros shared by the latency statistics block.
`ifndef LATENCY_STATS_PERCENTILE_CORE_MACROS_SVH
`define LATENCY_STATS_PERCENTILE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("latency stats assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("latency stats assertion failed");

`endif

@@ src/lsp_pkg.sv @@
// Package with constants and types for the latency statistics block.
`timescale 1ns / 1ps
package lsp_pkg;

    localparam int unsigned LSP_STORE_DEPTH = 256;
    localparam int unsigned PCT_W           = 7;
    localparam int unsigned PCT_SCALE       = 100;
    localparam int unsigned PCT_ROUND       = 99;
    localparam logic [PCT_W-1:0] PCT_FIRST_RST  = 7'd95;
    localparam logic [PCT_W-1:0] PCT_SECOND_RST = 7'd99;

    // Opcodes carried in the input tuser.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FIRST  = 1'b0;
    localparam logic CFG_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_RK_WAIT,
        ST_RK_ADDR,
        ST_RK_DATA,
        ST_OUT
    } t_state;

endpackage

@@ src/latency_stats_percentile_core.sv @@
// Top level of the latency statistics block with nearest-rank percentiles.
//
// Channel   | Direction | Handshake                    | Contents
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser opcode, tdata sample
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | report statistics
// cfg       | in        | i_cfg_valid/o_cfg_ready      | percent register writes
//
// A clear, an unused opcode and a record into an empty or full store finish in the idle state.
// Any other record moves through the shift state and, where needed, the place state:
// insertion shifts one entry per cycle through the single-read-port memory. A report
// makes two passes through the rank pipeline and memory reads and may then wait for the
// output register. Reset is synchronous and empties the statistics; no clearing pass
// is needed. A result waiting in the output register does not block input items until
// the next report needs it.
`timescale 1ns / 1ps
`include "latency_stats_percentile_core_macros.svh"
module latency_stats_percentile_core
    import lsp_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = LSP_STORE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,  // [31:0] sample_value
    input  logic [1:0]         s_axis_tuser,  // [1:0] opcode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [31:0] total_count, [63:32] min_value, [95:64] max_value, [159:96] value_sum,
    // [191:160] first_pct_value, [223:192] second_pct_value, [224] truncated
    output logic [231:0]       m_axis_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [PCT_W-1:0]   i_cfg_data
);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_state r_state, n_state;

    logic [PCT_W-1:0]   r_pct1, r_pct2;
    logic [31:0]        r_count;
    logic signed [31:0] r_min, r_max;
    logic [63:0]        r_sum;
    logic [CW-1:0]      r_stored;
    logic               r_trunc;
    logic signed [31:0] r_sample;
    logic [CW-1:0]      r_idx;
    logic               r_sel;
    logic               r_wait;
    logic signed [31:0] r_pv1, r_pv2;

    logic signed [31:0] r_mem [STORE_DEPTH];
    logic signed [31:0] r_rdata;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;

    logic               in_acc;
    logic               shift_more;
    logic               out_free;
    logic [AW-1:0]      rank_addr;
    logic signed [31:0] s_val;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign shift_more = (r_rdata > r_sample);
    assign out_free   = !m_axis_tvalid || m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign s_val      = s_axis_tdata;

    lsp_rank #(.STORE_DEPTH(STORE_DEPTH)) u_rank (
        .i_clk  (i_clk),
        .i_pct  (r_sel ? r_pct2 : r_pct1),
        .i_n    (r_stored),
        .o_addr (rank_addr)
    );

    // Sorted store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == OP_RECORD && r_stored < CW'(STORE_DEPTH)
                        && r_stored != '0) begin
                    n_state = ST_SHIFT;
                end else if (in_acc && s_axis_tuser == OP_REPORT) begin
                    n_state = ST_RK_WAIT;
                end
            end
            ST_SHIFT: begin
                if (!shift_more) begin
                    n_state = ST_IDLE;
                end else if (r_idx == CW'(1)) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE:   n_state = ST_IDLE;
            ST_RK_WAIT: if (r_wait) n_state = ST_RK_ADDR;
            ST_RK_ADDR: n_state = ST_RK_DATA;
            ST_RK_DATA: n_state = r_sel ? ST_OUT : ST_RK_WAIT;
            ST_OUT:     if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Memory controls and input ready.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = AW'(r_idx);
        mem_raddr = AW'(r_idx - CW'(2));
        mem_wdata = r_sample;
        case (r_state)
            ST_IDLE: begin
                mem_waddr = '0;
                mem_wdata = s_val;
                mem_raddr = AW'(r_stored - CW'(1));
                if (in_acc && s_axis_tuser == OP_RECORD && r_stored < CW'(STORE_DEPTH)) begin
                    mem_we = (r_stored == '0);
                    mem_re = (r_stored != '0);
                end
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_wdata = shift_more ? r_rdata : r_sample;
                mem_re    = shift_more && (r_idx > CW'(1));
            end
            ST_PLACE: mem_we = 1'b1;
            ST_RK_ADDR: begin
                mem_re    = 1'b1;
                mem_raddr = rank_addr;
            end
            default: ;
        endcase
    end

    // Statistics and report sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pct1        <= PCT_FIRST_RST;
            r_pct2        <= PCT_SECOND_RST;
            r_count       <= '0;
            r_min         <= '0;
            r_max         <= '0;
            r_sum         <= '0;
            r_stored      <= '0;
            r_trunc       <= 1'b0;
            r_sel         <= 1'b0;
            r_wait        <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FIRST) r_pct1 <= i_cfg_data;
                if (i_cfg_index == CFG_SECOND) r_pct2 <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_sel  <= 1'b0;
                    r_wait <= 1'b0;
                    if (in_acc && s_axis_tuser == OP_CLEAR) begin
                        r_count  <= '0;
                        r_min    <= '0;
                        r_max    <= '0;
                        r_sum    <= '0;
                        r_stored <= '0;
                        r_trunc  <= 1'b0;
                    end else if (in_acc && s_axis_tuser == OP_RECORD) begin
                        if (r_count == '0 || s_val < r_min) r_min <= s_val;
                        if (r_count == '0 || s_val > r_max) r_max <= s_val;
                        r_sum <= r_sum + {{32{s_val[31]}}, s_val};
                        if (r_count != '1) r_count <= r_count + 32'd1;
                        if (r_stored < CW'(STORE_DEPTH)) begin
                            r_stored <= r_stored + CW'(1);
                        end else begin
                            r_trunc <= 1'b1;
                        end
                    end
                end
                ST_RK_WAIT: r_wait <= !r_wait;
                ST_RK_DATA: begin
                    r_sel <= 1'b1;
                    if (r_sel) begin
                        r_pv2 <= (r_stored == '0) ? 32'sd0 : r_rdata;
                    end else begin
                        r_pv1 <= (r_stored == '0) ? 32'sd0 : r_rdata;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_axis_tvalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers without reset, including the insertion index.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= s_val;
            if (r_state == ST_IDLE) r_idx <= r_stored;
        end
        if (r_state == ST_SHIFT && shift_more) begin
            r_idx <= r_idx - CW'(1);
        end
        if (r_state == ST_OUT && out_free) begin
            m_axis_tdata <= {7'd0, r_trunc, r_pv2, r_pv1, r_sum, r_max, r_min, r_count};
        end
    end

    `LSP_ASSERT_NOW(a_stored_bound, i_clk, i_rst_n, 1'b1, r_stored <= CW'(STORE_DEPTH))
    `LSP_ASSERT_NOW(a_trunc_full, i_clk, i_rst_n, r_trunc, r_stored == CW'(STORE_DEPTH))
    `LSP_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, r_count == '0, r_stored == '0)
    `LSP_ASSERT_NOW(a_write_busy, i_clk, i_rst_n, mem_we && r_state != ST_IDLE,
        r_state == ST_SHIFT || r_state == ST_PLACE)
    `LSP_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == ST_OUT && out_free,
        m_axis_tvalid && r_state == ST_IDLE)

endmodule

@@ src/lsp_rank.sv @@
// Nearest-rank address pipeline: ceil(p*n/100) clamped to 1..n, minus one.
`timescale 1ns / 1ps
module lsp_rank
    import lsp_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = LSP_STORE_DEPTH,
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1),
    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic [PCT_W-1:0]      i_pct,
    input  logic [CW-1:0]         i_n,
    output logic [AW-1:0]         o_addr
);
    localparam int unsigned XW = PCT_W + CW + 1;
    localparam int unsigned K  = XW + 7;
    localparam int unsigned PW = XW + K;
    localparam int unsigned RW = XW + 7;
    localparam longint unsigned RECIP = (64'd1 << K) / PCT_SCALE;

    logic [XW-1:0] r_x;
    logic [XW-1:0] r_x2;
    logic [PW-1:0] r_prod;
    logic [CW-1:0] r_n1;
    logic [CW-1:0] r_n2;
    logic [XW-1:0] q0;
    logic [RW-1:0] rem;
    logic [XW-1:0] q;
    logic [XW-1:0] rank;

    // Stage 1: p*n plus rounding term; stage 2: multiply by reciprocal of 100.
    always_ff @(posedge i_clk) begin
        r_x    <= XW'(i_pct) * XW'(i_n) + XW'(PCT_ROUND);
        r_n1   <= i_n;
        r_prod <= PW'(r_x) * PW'(RECIP);
        r_x2   <= r_x;
        r_n2   <= r_n1;
    end

    // The reciprocal quotient is low by at most one; correct and clamp.
    always_comb begin
        q0  = r_prod[PW-1:K];
        rem = RW'(r_x2) - RW'(q0) * RW'(PCT_SCALE);
        q   = (rem >= RW'(PCT_SCALE)) ? q0 + XW'(1) : q0;
        if (q == '0) begin
            rank = XW'(1);
        end else if (q > XW'(r_n2)) begin
            rank = XW'(r_n2);
        end else begin
            rank = q;
        end
        o_addr = AW'(rank - XW'(1));
    end

endmodule

@@ test/tb_latency_stats_percentile_core.sv @@
// Self-checking testbench for the latency statistics block with nearest-rank percentiles.
`timescale 1ns / 1ps
module tb_latency_stats_percentile_core
    import lsp_pkg::*;
();

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         DRAIN_WAIT  = 300;
    localparam int         STALL_LIMIT = 5000;
    localparam int         ITEM_TARGET = 1900;

    // One report as seen on the output stream.
    typedef struct packed {
        logic [31:0]        count;
        logic signed [31:0] min_v;
        logic signed [31:0] max_v;
        logic [63:0]        sum;
        logic signed [31:0] pct1;
        logic signed [31:0] pct2;
        logic               trunc;
    } t_stats_report;

    // One row of the directed stimulus.
    typedef struct {
        logic [1:0]    op;
        logic [31:0]   sample;
        bit            typed;
        t_stats_report want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;
    logic [1:0]         s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [231:0]       m_axis_tdata;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [PCT_W-1:0]   i_cfg_data = '0;

    // Predictor state.
    logic [31:0]        pr_count;
    logic signed [31:0] pr_min;
    logic signed [31:0] pr_max;
    logic [63:0]        pr_sum;
    logic signed [31:0] pr_store [LSP_STORE_DEPTH];
    int unsigned        pr_stored;
    logic               pr_trunc;
    logic [PCT_W-1:0]   pr_pct1;
    logic [PCT_W-1:0]   pr_pct2;

    t_stats_report      pending_reports [$];
    t_stim_row          directed_rows [$];
    int                 error_count = 0;
    int                 items_sent = 0;
    bit                 quiet_send = 1'b0;
    bit                 quiet_recv = 1'b0;
    int                 recv_hold = 0;
    int                 idle_cycles = 0;

    latency_stats_percentile_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Nearest-rank lookup in the predicted sorted store.
    function automatic logic signed [31:0] rank_value(input logic [PCT_W-1:0] pct);
        int unsigned rank;
        if (pr_stored == 0) return '0;
        rank = (pct * pr_stored + 99) / 100;
        if (rank < 1) rank = 1;
        if (rank > pr_stored) rank = pr_stored;
        return pr_store[rank - 1];
    endfunction

    function automatic void clear_stats();
        pr_count  = '0;
        pr_min    = '0;
        pr_max    = '0;
        pr_sum    = '0;
        pr_stored = 0;
        pr_trunc  = 1'b0;
    endfunction

    // Updates the predicted statistics with one sample.
    function automatic void record_sample(input logic signed [31:0] v);
        int unsigned i;
        if (pr_count == 0) begin
            pr_min = v;
            pr_max = v;
        end else begin
            if (v < pr_min) pr_min = v;
            if (v > pr_max) pr_max = v;
        end
        pr_sum = pr_sum + {{32{v[31]}}, v};
        if (pr_count != 32'hFFFF_FFFF) pr_count = pr_count + 1;
        if (pr_stored < LSP_STORE_DEPTH) begin
            i = pr_stored;
            while (i > 0 && pr_store[i-1] > v) begin
                pr_store[i] = pr_store[i-1];
                i--;
            end
            pr_store[i] = v;
            pr_stored++;
        end else begin
            pr_trunc = 1'b1;
        end
    endfunction

    function automatic int draw_gap(input bit quiet);
        if (quiet) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [31:0] draw_sample();
        case ($urandom_range(0, 4))
            0: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return $urandom_range(0, 20) - 10;
            2: return $urandom_range(0, 5000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_row(input logic [1:0] op, input logic [31:0] sample,
                                     input bit typed, input t_stats_report want);
        t_stim_row r;
        r.op     = op;
        r.sample = sample;
        r.typed  = typed;
        r.want   = want;
        directed_rows.push_back(r);
    endfunction

    // Sends one item and updates the predictor when it is accepted.
    task automatic send_item(input logic [1:0] op, input logic [31:0] sample,
                             input bit typed, input t_stats_report want);
        int gap;
        t_stats_report rep;
        gap = draw_gap(quiet_send);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= sample;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
        case (op)
            OP_CLEAR:  clear_stats();
            OP_RECORD: record_sample(sample);
            OP_REPORT: begin
                rep.count = pr_count;
                rep.min_v = pr_min;
                rep.max_v = pr_max;
                rep.sum   = pr_sum;
                rep.pct1  = rank_value(pr_pct1);
                rep.pct2  = rank_value(pr_pct2);
                rep.trunc = pr_trunc;
                pending_reports.push_back(typed ? want : rep);
            end
            default: ;
        endcase
    endtask

    // Waits until every report is back and the block has finished any record.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Writes one register, then leaves the channel idle.
    task automatic write_cfg(input logic index, input logic [PCT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        if (index == CFG_FIRST) pr_pct1 = data;
        else pr_pct2 = data;
        @(posedge i_clk);
    endtask

    // Output side: random stalls, field-by-field comparison.
    always @(posedge i_clk) begin
        t_stats_report got;
        t_stats_report want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.count = m_axis_tdata[31:0];
                got.min_v = m_axis_tdata[63:32];
                got.max_v = m_axis_tdata[95:64];
                got.sum   = m_axis_tdata[159:96];
                got.pct1  = m_axis_tdata[191:160];
                got.pct2  = m_axis_tdata[223:192];
                got.trunc = m_axis_tdata[224];
                if (pending_reports.size() == 0) begin
                    $error("unexpected report item: %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.count !== want.count) begin
                        $error("total_count: expected %0d, got %0d", want.count, got.count);
                        error_count++;
                    end
                    if (got.min_v !== want.min_v) begin
                        $error("min_value: expected %0d, got %0d", want.min_v, got.min_v);
                        error_count++;
                    end
                    if (got.max_v !== want.max_v) begin
                        $error("max_value: expected %0d, got %0d", want.max_v, got.max_v);
                        error_count++;
                    end
                    if (got.sum !== want.sum) begin
                        $error("value_sum: expected %h, got %h", want.sum, got.sum);
                        error_count++;
                    end
                    if (got.pct1 !== want.pct1) begin
                        $error("first_pct_value: expected %0d, got %0d", want.pct1, got.pct1);
                        error_count++;
                    end
                    if (got.pct2 !== want.pct2) begin
                        $error("second_pct_value: expected %0d, got %0d",
                               want.pct2, got.pct2);
                        error_count++;
                    end
                    if (got.trunc !== want.trunc) begin
                        $error("truncated: expected %0d, got %0d", want.trunc, got.trunc);
                        error_count++;
                    end
                end
                recv_hold = draw_gap(quiet_recv);
            end else if (recv_hold > 0) begin
                recv_hold--;
            end
            m_axis_tready <= (recv_hold == 0);
        end
    end

    // Watchdog on cycles with no accepted item on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL latency_stats_percentile_core");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases under several settings.
    initial begin
        t_stats_report z;
        t_stats_report one_max;
        int phase_len;
        int roll;
        z = '0;
        one_max = '{count: 32'd1, min_v: 32'h7FFF_FFFF, max_v: 32'h7FFF_FFFF,
                    sum: 64'h0000_0000_7FFF_FFFF, pct1: 32'h7FFF_FFFF,
                    pct2: 32'h7FFF_FFFF, trunc: 1'b0};
        pr_pct1 = PCT_FIRST_RST;
        pr_pct2 = PCT_SECOND_RST;
        clear_stats();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty report, extremes, unused opcode, clear.
        push_row(OP_REPORT, 32'd0, 1'b1, z);
        push_row(OP_UNUSED, 32'h1234_5678, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b1, z);
        push_row(OP_RECORD, 32'h7FFF_FFFF, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b1, one_max);
        push_row(OP_RECORD, 32'h8000_0000, 1'b0, z);
        push_row(OP_RECORD, 32'd0, 1'b0, z);
        push_row(OP_RECORD, 32'hFFFF_FFFF, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b0, z);
        push_row(OP_RECORD, 32'h7FFF_FFFF, 1'b0, z);
        push_row(OP_RECORD, 32'h7FFF_FFFF, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b0, z);
        push_row(OP_CLEAR, 32'hFFFF_FFFF, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b1, z);
        push_row(OP_RECORD, 32'hFFFF_FFFF, 1'b0, z);
        push_row(OP_RECORD, 32'd5, 1'b0, z);
        push_row(OP_RECORD, 32'd3, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b0, z);
        push_row(OP_UNUSED, 32'd0, 1'b0, z);
        push_row(OP_REPORT, 32'd0, 1'b0, z);
        foreach (directed_rows[k])
            send_item(directed_rows[k].op, directed_rows[k].sample,
                      directed_rows[k].typed, directed_rows[k].want);

        // Random phases; the first few use the extreme settings.
        for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
            drain();
            case (ph)
                0: begin write_cfg(CFG_FIRST, 7'd0);   write_cfg(CFG_SECOND, 7'd127); end
                1: begin write_cfg(CFG_FIRST, 7'd127); write_cfg(CFG_SECOND, 7'd0);   end
                2: begin write_cfg(CFG_FIRST, 7'd1);   write_cfg(CFG_SECOND, 7'd100); end
                3: begin write_cfg(CFG_FIRST, 7'd100); write_cfg(CFG_SECOND, 7'd50);  end
                default: begin
                    write_cfg(CFG_FIRST, $urandom_range(0, 127));
                    write_cfg(CFG_SECOND, $urandom_range(0, 127));
                end
            endcase
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
            if (ph == 1 || ph == 5) begin
                // Fill the store past its depth so the truncated flag is exercised.
                send_item(OP_CLEAR, draw_sample(), 1'b0, z);
                for (int n = 0; n < LSP_STORE_DEPTH + 40; n++) begin
                    send_item(($urandom_range(0, 11) == 0) ? OP_REPORT : OP_RECORD,
                              draw_sample(), 1'b0, z);
                end
                send_item(OP_REPORT, 32'd0, 1'b0, z);
            end else begin
                phase_len = $urandom_range(100, 200);
                send_item(OP_CLEAR, draw_sample(), 1'b0, z);
                for (int n = 0; n < phase_len; n++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        send_item(OP_UNUSED, $urandom, 1'b0, z);
                    else if (roll < 6)
                        send_item(OP_CLEAR, $urandom, 1'b0, z);
                    else if (roll < 22)
                        send_item(OP_REPORT, $urandom, 1'b0, z);
                    else
                        send_item(OP_RECORD, draw_sample(), 1'b0, z);
                end
                send_item(OP_REPORT, 32'd0, 1'b0, z);
            end
        end

        drain();
        if (error_count == 0) begin
            $display("PASS latency_stats_percentile_core");
        end else begin
            $display("FAIL latency_stats_percentile_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/lsp_pkg.sv
src/lsp_rank.sv
src/latency_stats_percentile_core.sv
test/tb_latency_stats_percentile_core.sv
